// ===== src/reconnect_backoff_controller_assert.svh =====
// Assertion helpers for the checker file of the reconnect controller.
`ifndef RECONNECT_BACKOFF_CONTROLLER_ASSERT_SVH
`define RECONNECT_BACKOFF_CONTROLLER_ASSERT_SVH

// Clocked assertion that is switched off while reset is active.
`define RBC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked while reset is active.
`define RBC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/rbc_pkg.sv =====
`timescale 1ns / 1ps

package rbc_pkg;

  // Field widths.
  localparam int TimeBits = 32;
  localparam int DelayW   = 20;
  localparam int CountW   = 8;
  localparam int OpW      = 3;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  // Event codes carried in the op field.
  localparam logic [OpW-1:0] OpCommand  = 3'd0;
  localparam logic [OpW-1:0] OpPoll     = 3'd1;
  localparam logic [OpW-1:0] OpAttempt  = 3'd2;
  localparam logic [OpW-1:0] OpResched  = 3'd3;
  localparam logic [OpW-1:0] OpClear    = 3'd4;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegBaseDelay = 2'd1;
  localparam logic [1:0] RegMaxDelay  = 2'd2;

  // Register reset values.
  localparam logic [CountW-1:0] ThresholdRst = 8'd3;
  localparam logic [DelayW-1:0] BaseDelayRst = 20'd1000;
  localparam logic [DelayW-1:0] MaxDelayRst  = 20'd60000;

  // Input beat.
  typedef struct packed {
    logic [OpW-1:0]      op;
    logic                success;
    logic [TimeBits-1:0] now_ms;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic                attempt_request;
    logic                pending;
    logic [CountW-1:0]   attempts;
    logic [TimeBits-1:0] next_due_ms;
    logic [DelayW-1:0]   backoff_ms;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [CountW-1:0] failure_threshold;
    logic [DelayW-1:0] base_delay_ms;
    logic [DelayW-1:0] max_delay_ms;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit_fast;
    logic start_dbl;
    logic step_dbl;
    logic commit_slow;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slow_path;
    logic dbl_done;
    logic slot_free;
  } dp_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StDouble,
    StWrite
  } state_e;

endpackage

// ===== src/rbc_regs.sv =====
`timescale 1ns / 1ps

module rbc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbc_pkg::AddrW-1:0]   paddr,
  input  logic [rbc_pkg::DataW-1:0]   pwdata,
  output logic [rbc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output rbc_pkg::cfg_t               cfg_o
);

  rbc_pkg::cfg_t cfg_q;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failure_threshold <= rbc_pkg::ThresholdRst;
      cfg_q.base_delay_ms     <= rbc_pkg::BaseDelayRst;
      cfg_q.max_delay_ms      <= rbc_pkg::MaxDelayRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        rbc_pkg::RegThreshold: cfg_q.failure_threshold <= pwdata[rbc_pkg::CountW-1:0];
        rbc_pkg::RegBaseDelay: cfg_q.base_delay_ms     <= pwdata[rbc_pkg::DelayW-1:0];
        rbc_pkg::RegMaxDelay:  cfg_q.max_delay_ms      <= pwdata[rbc_pkg::DelayW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux; unmapped addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      rbc_pkg::RegThreshold: begin
        prdata = {{(rbc_pkg::DataW-rbc_pkg::CountW){1'b0}}, cfg_q.failure_threshold};
      end
      rbc_pkg::RegBaseDelay: begin
        prdata = {{(rbc_pkg::DataW-rbc_pkg::DelayW){1'b0}}, cfg_q.base_delay_ms};
      end
      rbc_pkg::RegMaxDelay: begin
        prdata = {{(rbc_pkg::DataW-rbc_pkg::DelayW){1'b0}}, cfg_q.max_delay_ms};
      end
      default: prdata = '0;
    endcase
  end

endmodule

// ===== src/rbc_ctrl.sv =====
`timescale 1ns / 1ps

module rbc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  rbc_pkg::dp_status_t  status_i,
  output rbc_pkg::ctrl_cmd_t   cmd_o,
  output logic                 in_stall_o
);

  rbc_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbc_pkg::StIdle: begin
        if (in_valid_i) state_d = rbc_pkg::StExec;
      end
      rbc_pkg::StExec: begin
        if (status_i.slow_path) begin
          state_d = rbc_pkg::StDouble;
        end else if (status_i.slot_free) begin
          state_d = rbc_pkg::StIdle;
        end
      end
      rbc_pkg::StDouble: begin
        if (status_i.dbl_done) state_d = rbc_pkg::StWrite;
      end
      rbc_pkg::StWrite: begin
        if (status_i.slot_free) state_d = rbc_pkg::StIdle;
      end
      default: state_d = rbc_pkg::StIdle;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != rbc_pkg::StIdle);
    unique case (state_q)
      rbc_pkg::StIdle: begin
        cmd_o.capture = in_valid_i;
      end
      rbc_pkg::StExec: begin
        cmd_o.start_dbl   = status_i.slow_path;
        cmd_o.commit_fast = !status_i.slow_path && status_i.slot_free;
      end
      rbc_pkg::StDouble: begin
        cmd_o.step_dbl = !status_i.dbl_done;
      end
      rbc_pkg::StWrite: begin
        cmd_o.commit_slow = status_i.slot_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/rbc_datapath.sv =====
`timescale 1ns / 1ps

module rbc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rbc_pkg::in_item_t    in_data_i,
  input  rbc_pkg::cfg_t        cfg_i,
  input  rbc_pkg::ctrl_cmd_t   cmd_i,
  input  logic                 out_stall_i,
  output rbc_pkg::dp_status_t  status_o,
  output logic                 out_valid_o,
  output rbc_pkg::out_item_t   out_data_o
);

  // Captured event.
  rbc_pkg::in_item_t in_q;

  // Link state.
  logic [rbc_pkg::CountW-1:0]   fail_cnt_q, fail_cnt_d;
  logic                         pending_q, pending_d;
  logic [rbc_pkg::CountW-1:0]   attempts_q, attempts_d;
  logic [rbc_pkg::TimeBits-1:0] next_due_q, next_due_d;
  logic [rbc_pkg::DelayW-1:0]   last_backoff_q, last_backoff_d;

  // Doubling unit.
  logic [rbc_pkg::DelayW-1:0]   delay_q;
  logic [rbc_pkg::CountW-1:0]   step_q;
  logic [rbc_pkg::DelayW-1:0]   half_delay;
  logic [rbc_pkg::DelayW-1:0]   capped_delay;

  // Output register.
  rbc_pkg::out_item_t           out_q;
  logic                         out_valid_q;
  logic                         request;
  logic [rbc_pkg::CountW-1:0]   fail_inc;

  assign half_delay   = cfg_i.max_delay_ms >> 1;
  assign capped_delay = (delay_q > cfg_i.max_delay_ms) ? cfg_i.max_delay_ms : delay_q;
  assign fail_inc     = (fail_cnt_q != {rbc_pkg::CountW{1'b1}}) ? fail_cnt_q + 8'd1
                                                                : fail_cnt_q;

  // Status toward the controller.
  assign status_o.slow_path = (in_q.op == rbc_pkg::OpAttempt) && pending_q && !in_q.success;
  assign status_o.dbl_done  = (step_q == attempts_q) || (delay_q >= half_delay) ||
                              (delay_q == '0);
  assign status_o.slot_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Event capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
  end

  // Next link state for the current event.
  always_comb begin
    fail_cnt_d     = fail_cnt_q;
    pending_d      = pending_q;
    attempts_d     = attempts_q;
    next_due_d     = next_due_q;
    last_backoff_d = last_backoff_q;
    request        = 1'b0;
    if (cmd_i.start_dbl) begin
      attempts_d = attempts_q + 8'd1;
    end else if (cmd_i.commit_slow) begin
      last_backoff_d = capped_delay;
      next_due_d     = in_q.now_ms +
                       {{(rbc_pkg::TimeBits-rbc_pkg::DelayW){1'b0}}, capped_delay};
    end else if (cmd_i.commit_fast) begin
      unique case (in_q.op)
        rbc_pkg::OpCommand: begin
          if (in_q.success) begin
            fail_cnt_d = '0;
          end else begin
            fail_cnt_d = fail_inc;
            if (fail_inc >= cfg_i.failure_threshold) begin
              if (!pending_q) begin
                pending_d  = 1'b1;
                attempts_d = '0;
              end
              if (next_due_q == '0) next_due_d = in_q.now_ms;
            end
          end
        end
        rbc_pkg::OpPoll: begin
          request = pending_q && (in_q.now_ms >= next_due_q);
        end
        rbc_pkg::OpAttempt: begin
          // A failed attempt on a pending link takes the doubling path instead.
          if (pending_q && in_q.success) begin
            fail_cnt_d = '0;
            pending_d  = 1'b0;
            attempts_d = '0;
            next_due_d = '0;
          end
        end
        rbc_pkg::OpResched: begin
          if (pending_q) next_due_d = in_q.now_ms;
        end
        rbc_pkg::OpClear: begin
          fail_cnt_d     = '0;
          pending_d      = 1'b0;
          attempts_d     = '0;
          next_due_d     = '0;
          last_backoff_d = '0;
        end
        default: ;
      endcase
    end
  end

  // Link state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_cnt_q     <= '0;
      pending_q      <= 1'b0;
      attempts_q     <= '0;
      next_due_q     <= '0;
      last_backoff_q <= '0;
    end else begin
      fail_cnt_q     <= fail_cnt_d;
      pending_q      <= pending_d;
      attempts_q     <= attempts_d;
      next_due_q     <= next_due_d;
      last_backoff_q <= last_backoff_d;
    end
  end

  // Doubling unit: one shift per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_dbl) begin
      delay_q <= cfg_i.base_delay_ms;
      step_q  <= '0;
    end else if (cmd_i.step_dbl) begin
      delay_q <= delay_q << 1;
      step_q  <= step_q + 8'd1;
    end
  end

  // Result payload, loaded with the state after the event.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_fast || cmd_i.commit_slow) begin
      out_q.attempt_request <= request;
      out_q.pending         <= pending_d;
      out_q.attempts        <= attempts_d;
      out_q.next_due_ms     <= next_due_d;
      out_q.backoff_ms      <= last_backoff_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_fast || cmd_i.commit_slow) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// ===== src/reconnect_backoff_controller.sv =====
`timescale 1ns / 1ps
// Reconnect backoff controller.
// Events arrive on the input channel (in_valid_i / in_stall_o, payload in_data_i);
// each event yields exactly one result beat on the output channel
// (out_valid_o / out_stall_i, payload out_data_o) holding the link state after it.
// Threshold, base delay and maximum delay are set through the APB port at byte
// addresses 0, 4 and 8; write them only while no event is in flight.
// Flow: an event is taken into an input register, then handled by a small
// sequencer. Most events are settled in the execute state, which writes the
// result into the output register and returns to idle; no new event is taken
// before that. A failed reconnect attempt on a pending link also runs the
// doubling unit, one shift per cycle, for at most min(attempts, 19) shifts. Once
// it ends, the write state caps the delay and schedules the next due time.
// A new event is accepted while an earlier result waits in the output register.
// When the receiver stalls, the result is held unchanged and the sequencer waits
// before writing the following result.
// Reset clears the link state, drops any result and loads the register defaults.
module reconnect_backoff_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rbc_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rbc_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbc_pkg::AddrW-1:0]  paddr,
  input  logic [rbc_pkg::DataW-1:0]  pwdata,
  output logic [rbc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  rbc_pkg::cfg_t       cfg;
  rbc_pkg::ctrl_cmd_t  cmd;
  rbc_pkg::dp_status_t status;

  // Configuration registers.
  rbc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer.
  rbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Link state, doubling unit and output register.
  rbc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/rbc_checker.sv =====
`timescale 1ns / 1ps
`include "reconnect_backoff_controller_assert.svh"

module rbc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rbc_pkg::out_item_t out_data_o
);

  // A stalled result beat stays and holds its payload.
  `RBC_ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result beat changed")

  // An attempt request only comes with a pending reconnect.
  `RBC_ASSERT_CLK(a_req_pending, out_valid_o && out_data_o.attempt_request |-> out_data_o.pending, "attempt request without pending reconnect")

  // Without a pending reconnect there is no attempt count and no schedule.
  `RBC_ASSERT_CLK(a_idle_link, out_valid_o && !out_data_o.pending |-> (out_data_o.attempts == 8'd0) && (out_data_o.next_due_ms == '0), "idle link reports attempts or schedule")

  // No result beat is offered during reset.
  `RBC_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o, "result beat during reset")

endmodule

bind reconnect_backoff_controller rbc_checker u_rbc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 1_000_000;
  localparam int PhaseBeats = 200;
  // Op codes the block has no use for; they must leave the state alone.
  localparam logic [rbc_pkg::OpW-1:0] OpSpareLo = 3'd5;
  localparam logic [rbc_pkg::OpW-1:0] OpSpareHi = 3'd7;
  localparam rbc_pkg::out_item_t Quiet = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  rbc_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rbc_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rbc_pkg::AddrW-1:0] paddr = '0;
  logic [rbc_pkg::DataW-1:0] pwdata = '0;
  logic [rbc_pkg::DataW-1:0] prdata;
  logic pready;

  reconnect_backoff_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the registers and of the link state.
  logic [rbc_pkg::CountW-1:0]   cfg_thr;
  logic [rbc_pkg::DelayW-1:0]   cfg_base;
  logic [rbc_pkg::DelayW-1:0]   cfg_max;
  logic [rbc_pkg::CountW-1:0]   fail_run;
  logic                         link_pending;
  logic [rbc_pkg::CountW-1:0]   retry_count;
  logic [rbc_pkg::TimeBits-1:0] due_ms;
  logic [rbc_pkg::DelayW-1:0]   backoff_hold;

  rbc_pkg::out_item_t result_q[$];
  int errors = 0;
  int cycle_count = 0;
  int beats_sent = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  logic [rbc_pkg::TimeBits-1:0] wall;

  typedef struct {
    rbc_pkg::in_item_t  beat;
    bit                 typed;
    rbc_pkg::out_item_t want;
  } script_row_t;
  script_row_t script[$];

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Delay after a failed attempt: base doubled per attempt while below half the cap, then capped.
  function automatic logic [rbc_pkg::DelayW-1:0] capped_backoff(
      input logic [rbc_pkg::CountW-1:0] n);
    logic [rbc_pkg::DelayW:0]   d;
    logic [rbc_pkg::DelayW-1:0] half;
    int i;
    d = {1'b0, cfg_base};
    half = cfg_max >> 1;
    for (i = 0; i < int'(n) && d < {1'b0, half}; i++) d = d << 1;
    if (d > {1'b0, cfg_max}) d = {1'b0, cfg_max};
    return d[rbc_pkg::DelayW-1:0];
  endfunction

  // Apply one event to the shadow state and return the expected result beat.
  function automatic rbc_pkg::out_item_t advance_link(input rbc_pkg::in_item_t b);
    rbc_pkg::out_item_t r;
    r = '0;
    case (b.op)
      rbc_pkg::OpCommand: begin
        if (b.success) begin
          fail_run = '0;
        end else begin
          if (fail_run != 8'hFF) fail_run = fail_run + 1'b1;
          if (fail_run >= cfg_thr) begin
            if (!link_pending) begin
              link_pending = 1'b1;
              retry_count = '0;
            end
            if (due_ms == '0) due_ms = b.now_ms;
          end
        end
      end
      rbc_pkg::OpPoll: begin
        r.attempt_request = link_pending && (b.now_ms >= due_ms);
      end
      rbc_pkg::OpAttempt: begin
        if (link_pending) begin
          if (b.success) begin
            fail_run = '0;
            link_pending = 1'b0;
            retry_count = '0;
            due_ms = '0;
          end else begin
            retry_count = retry_count + 1'b1;
            backoff_hold = capped_backoff(retry_count);
            due_ms = b.now_ms + rbc_pkg::TimeBits'(backoff_hold);
          end
        end
      end
      rbc_pkg::OpResched: begin
        if (link_pending) due_ms = b.now_ms;
      end
      rbc_pkg::OpClear: begin
        fail_run = '0;
        link_pending = 1'b0;
        retry_count = '0;
        due_ms = '0;
        backoff_hold = '0;
      end
      default: ;
    endcase
    r.pending = link_pending;
    r.attempts = retry_count;
    r.next_due_ms = due_ms;
    r.backoff_ms = backoff_hold;
    return r;
  endfunction

  // Offer one beat, hold it until taken, then record what it should produce.
  task automatic send(input rbc_pkg::in_item_t beat, input bit typed,
                      input rbc_pkg::out_item_t want);
    int gap;
    rbc_pkg::out_item_t model_res;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    model_res = advance_link(beat);
    result_q.push_back(typed ? want : model_res);
    beats_sent++;
    if ($urandom_range(0, 59) == 0) calm = !calm;
  endtask

  task automatic post_event(input logic [rbc_pkg::OpW-1:0] op, input logic ok,
                            input logic [rbc_pkg::TimeBits-1:0] t);
    send(rbc_pkg::in_item_t'{op, ok, t}, 1'b0, Quiet);
  endtask

  task automatic plan_row(input logic [rbc_pkg::OpW-1:0] op, input logic ok,
                          input logic [rbc_pkg::TimeBits-1:0] t, input bit typed,
                          input rbc_pkg::out_item_t want);
    script_row_t row;
    row.beat = rbc_pkg::in_item_t'{op, ok, t};
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endtask

  // Stop offering beats and wait until every result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_reg(input logic [1:0] idx, input logic [rbc_pkg::DataW-1:0] val);
    logic [rbc_pkg::DataW-1:0] held;
    case (idx)
      rbc_pkg::RegThreshold: begin
        cfg_thr = val[rbc_pkg::CountW-1:0];
        held = rbc_pkg::DataW'(val[rbc_pkg::CountW-1:0]);
      end
      rbc_pkg::RegBaseDelay: begin
        cfg_base = val[rbc_pkg::DelayW-1:0];
        held = rbc_pkg::DataW'(val[rbc_pkg::DelayW-1:0]);
      end
      default: begin
        cfg_max = val[rbc_pkg::DelayW-1:0];
        held = rbc_pkg::DataW'(val[rbc_pkg::DelayW-1:0]);
      end
    endcase
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rbc_pkg::AddrW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== held) begin
      $error("register %0d readback: expected %h, got %h", idx, held, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int thr, input int base, input int cap);
    drain();
    write_reg(rbc_pkg::RegThreshold, rbc_pkg::DataW'(thr));
    write_reg(rbc_pkg::RegBaseDelay, rbc_pkg::DataW'(base));
    write_reg(rbc_pkg::RegMaxDelay, rbc_pkg::DataW'(cap));
  endtask

  // A link outage: failures toward the threshold, polls and failed retries, then mostly recovery.
  task automatic outage();
    int k;
    int rounds;
    int i;
    int r;
    k = (int'(cfg_thr) > int'(fail_run)) ? int'(cfg_thr) - int'(fail_run) : 1;
    if (k > 12) k = 12;
    k += $urandom_range(0, 2);
    for (i = 0; i < k; i++) begin
      wall += $urandom_range(0, 20);
      if (i > 0 && $urandom_range(0, 15) == 0) post_event(rbc_pkg::OpCommand, 1'b1, wall);
      post_event(rbc_pkg::OpCommand, 1'b0, wall);
    end
    rounds = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
    for (i = 0; i < rounds; i++) begin
      if (link_pending && due_ms > 32'd8 && $urandom_range(0, 1) == 0)
        post_event(rbc_pkg::OpPoll, 1'($urandom), due_ms - $urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) begin
        wall += $urandom_range(0, 9);
        post_event(rbc_pkg::OpResched, 1'($urandom), wall);
      end
      if (link_pending) wall = due_ms;
      post_event(rbc_pkg::OpPoll, 1'($urandom), wall + $urandom_range(0, 3));
      wall += $urandom_range(0, 5);
      post_event(rbc_pkg::OpAttempt, 1'b0, wall);
    end
    r = $urandom_range(0, 9);
    wall += $urandom_range(0, 50);
    if (r < 7) post_event(rbc_pkg::OpAttempt, 1'b1, wall);
    else if (r == 7) post_event(rbc_pkg::OpClear, 1'($urandom), wall);
    else if (r == 8) post_event(rbc_pkg::OpCommand, 1'b1, wall);
  endtask

  // Arbitrary beats with any op code and any time.
  task automatic noise();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) post_event(rbc_pkg::OpW'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic random_phase();
    int goal;
    goal = beats_sent + PhaseBeats;
    case ($urandom_range(0, 2))
      0: wall = '0;
      1: wall = $urandom;
      default: wall = 32'hFFFF_FF00 + $urandom_range(0, 255);
    endcase
    while (beats_sent < goal) begin
      if ($urandom_range(0, 4) == 0) noise();
      else outage();
    end
  endtask

  // Result side: random stalls, and every accepted beat is checked in order.
  always @(posedge clk_i) begin
    rbc_pkg::out_item_t got;
    rbc_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: %h", got);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.attempt_request !== want.attempt_request) begin
            $error("attempt_request: expected %0d, got %0d",
                   want.attempt_request, got.attempt_request);
            errors++;
          end
          if (got.pending !== want.pending) begin
            $error("pending: expected %0d, got %0d", want.pending, got.pending);
            errors++;
          end
          if (got.attempts !== want.attempts) begin
            $error("attempts: expected %0d, got %0d", want.attempts, got.attempts);
            errors++;
          end
          if (got.next_due_ms !== want.next_due_ms) begin
            $error("next_due_ms: expected %h, got %h", want.next_due_ms, got.next_due_ms);
            errors++;
          end
          if (got.backoff_ms !== want.backoff_ms) begin
            $error("backoff_ms: expected %0d, got %0d", want.backoff_ms, got.backoff_ms);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    // A falling reset edge at time zero so the block is cleared before the first clock.
    rst_ni <= 1'b0;
    cfg_thr = rbc_pkg::ThresholdRst;
    cfg_base = rbc_pkg::BaseDelayRst;
    cfg_max = rbc_pkg::MaxDelayRst;
    fail_run = '0;
    link_pending = 1'b0;
    retry_count = '0;
    due_ms = '0;
    backoff_hold = '0;

    // Directed sequence at the reset register values (threshold 3, base 1000, cap 60000).
    plan_row(rbc_pkg::OpPoll, 1'b0, 32'd0, 1'b1, Quiet);
    plan_row(rbc_pkg::OpAttempt, 1'b0, 32'd5, 1'b1, Quiet);
    plan_row(rbc_pkg::OpResched, 1'b1, 32'd7, 1'b1, Quiet);
    plan_row(OpSpareLo, 1'b1, 32'hFFFF_FFFF, 1'b1, Quiet);
    plan_row(OpSpareHi, 1'b0, 32'd9, 1'b1, Quiet);
    plan_row(rbc_pkg::OpClear, 1'b1, 32'd10, 1'b1, Quiet);
    plan_row(rbc_pkg::OpCommand, 1'b0, 32'd100, 1'b1, Quiet);
    plan_row(rbc_pkg::OpCommand, 1'b1, 32'd101, 1'b1, Quiet);
    plan_row(rbc_pkg::OpCommand, 1'b0, 32'd200, 1'b0, Quiet);
    plan_row(rbc_pkg::OpCommand, 1'b0, 32'd201, 1'b0, Quiet);
    plan_row(rbc_pkg::OpCommand, 1'b0, 32'd202, 1'b1,
             rbc_pkg::out_item_t'{1'b0, 1'b1, 8'd0, 32'd202, 20'd0});
    plan_row(rbc_pkg::OpPoll, 1'b0, 32'd201, 1'b1,
             rbc_pkg::out_item_t'{1'b0, 1'b1, 8'd0, 32'd202, 20'd0});
    plan_row(rbc_pkg::OpPoll, 1'b1, 32'd202, 1'b1,
             rbc_pkg::out_item_t'{1'b1, 1'b1, 8'd0, 32'd202, 20'd0});
    plan_row(rbc_pkg::OpAttempt, 1'b0, 32'd1000, 1'b1,
             rbc_pkg::out_item_t'{1'b0, 1'b1, 8'd1, 32'd3000, 20'd2000});
    // The next due time wraps past the top of the time range.
    plan_row(rbc_pkg::OpAttempt, 1'b0, 32'hFFFF_FFFF, 1'b1,
             rbc_pkg::out_item_t'{1'b0, 1'b1, 8'd2, 32'd3999, 20'd4000});
    plan_row(rbc_pkg::OpCommand, 1'b0, 32'd5000, 1'b0, Quiet);
    plan_row(rbc_pkg::OpResched, 1'b0, 32'hFFFF_FFFF, 1'b0, Quiet);
    plan_row(rbc_pkg::OpPoll, 1'b0, 32'hFFFF_FFFE, 1'b0, Quiet);
    plan_row(rbc_pkg::OpPoll, 1'b0, 32'hFFFF_FFFF, 1'b0, Quiet);
    // Wrap lands exactly on zero, which reads as unset.
    plan_row(rbc_pkg::OpAttempt, 1'b0, 32'hFFFF_E0C0, 1'b1,
             rbc_pkg::out_item_t'{1'b0, 1'b1, 8'd3, 32'd0, 20'd8000});
    plan_row(rbc_pkg::OpCommand, 1'b0, 32'd42, 1'b0, Quiet);
    plan_row(rbc_pkg::OpAttempt, 1'b1, 32'd50, 1'b1,
             rbc_pkg::out_item_t'{1'b0, 1'b0, 8'd0, 32'd0, 20'd8000});
    plan_row(rbc_pkg::OpClear, 1'b0, 32'd60, 1'b1, Quiet);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) send(script[i].beat, script[i].typed, script[i].want);
    random_phase();

    // Smallest base with the widest cap: longest doubling, and the retry counter wraps.
    set_config(1, 1, 20'hFFFFF);
    wall = 32'd500;
    post_event(rbc_pkg::OpCommand, 1'b0, wall);
    repeat (260) begin
      wall += $urandom_range(0, 7);
      post_event(rbc_pkg::OpAttempt, 1'b0, wall);
    end
    random_phase();

    // Highest threshold: the failure count has to saturate.
    set_config(255, 20'hFFFFF, 20'hFFFFF);
    wall = $urandom;
    repeat (270) begin
      wall += $urandom_range(0, 3);
      post_event(rbc_pkg::OpCommand, 1'b0, wall);
    end
    random_phase();

    // Zero threshold and zero base delay.
    set_config(0, 0, 1);
    random_phase();

    // Base above the cap.
    set_config(2, 3, 1);
    random_phase();

    set_config($urandom_range(1, 6), $urandom_range(1, 5000), $urandom_range(1, 200000));
    random_phase();

    set_config($urandom_range(1, 4), $urandom_range(0, 20'hFFFFF),
               $urandom_range(0, 20'hFFFFF));
    random_phase();

    drain();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
